// File: hdl/paq_pkg.sv
// Shared types and constants for the priority admission queue.
package paq_pkg;

    localparam int MODE_W   = 3;
    localparam int CLIENT_W = 16;
    localparam int PRIO_W   = 8;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int PERIOD_W = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Input transaction modes
    localparam logic [MODE_W-1:0] MODE_ENQ  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POLL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK = 3'd4;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_POS    = 2'd0,
        KIND_ADMIT  = 2'd1,
        KIND_POLL   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // One waiting-list entry as held in the entry memory
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [CLIENT_W-1:0] client;
    } t_entry;

endpackage

// File: hdl/priority_admission_queue.sv
// Top level of the priority admission queue: period register, sequencer
// and entry memory.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------------
//  input    | in        | i_in_valid / o_in_ready  | i_mode, i_client_id, i_priority_req
//  result   | out       | o_out_valid / i_out_ready| o_kind, o_client_out, o_position,
//           |           |                          | o_last, o_queue_count
//  config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_data (update period)
//
// One transaction at a time; the walk over the entry memory moves one entry
// per cycle through its single read and single write port.
// Enqueue moves entries of larger priority up one slot, then writes the
// new entry into the hole; a full list rejects it. Dequeue and poll search
// from the front; free slot admits the front entry and closes the gap; a
// broadcast sends one update per entry. Tick without broadcast and ignored modes end in idle.
// Result stalls hold the walk; a new transaction is taken once the walk ends,
// even while the last result still waits in the output register.
// Reset is synchronous; the entry memory needs no clearing pass.
module priority_admission_queue
    import paq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [CLIENT_W-1:0] i_client_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [CLIENT_W-1:0] o_client_out,
    output logic [POS_W-1:0]    o_position,
    output logic                o_last,
    output logic [POS_W-1:0]    o_queue_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PERIOD_W-1:0] r_period;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    t_entry              mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    t_entry              mem_rd_data;
    logic [CW-1:0]       count;

    // Update period register; always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    paq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_client_id    (i_client_id),
        .i_priority_req (i_priority_req),
        .i_period       (r_period),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_client_out   (o_client_out),
        .o_position     (o_position),
        .o_last         (o_last),
        .o_queue_count  (o_queue_count),
        .o_wr_en        (mem_wr_en),
        .o_wr_addr      (mem_wr_addr),
        .o_wr_data      (mem_wr_data),
        .o_rd_en        (mem_rd_en),
        .o_rd_addr      (mem_rd_addr),
        .i_rd_data      (mem_rd_data),
        .o_count        (count)
    );

    paq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Entry count never exceeds the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    // Entry count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (count == $past(count)) || (count == CW'($past(count) + 1'b1)) ||
        (count == CW'($past(count) - 1'b1)))
        else $error("entry count jumped");

    // Admit, poll and reject results are single and so always final
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != KIND_POS)) |-> o_last)
        else $error("single result without last");

endmodule

// File: hdl/paq_mem.sv
// Entry memory: one write port, one read port with registered read data.
module paq_mem
    import paq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int AW          = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/paq_ctrl.sv
// Sequencer: walks the entry memory one entry per cycle unless a result stall
// holds it (insert, search, removal, broadcast); holds the timer and the result register.
module paq_ctrl
    import paq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int AW          = 5,
    parameter int CW          = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [CLIENT_W-1:0] i_client_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    // configuration
    input  logic [PERIOD_W-1:0] i_period,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [CLIENT_W-1:0] o_client_out,
    output logic [POS_W-1:0]    o_position,
    output logic                o_last,
    output logic [POS_W-1:0]    o_queue_count,
    // entry memory
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output t_entry              o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  t_entry              i_rd_data,
    // status
    output logic [CW-1:0]       o_count
);

    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_FIN,
        S_SRCH,
        S_SHIFT,
        S_FREE,
        S_REJ,
        S_BCAST
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_dirty, n_dirty;
    logic                  r_run, n_run;
    logic [PERIOD_W-1:0]   r_tick, n_tick;
    logic                  r_poll, n_poll;
    logic [CLIENT_W-1:0]   r_cid, n_cid;
    logic [PRIO_W-1:0]     r_prio, n_prio;
    logic                  r_out_valid, n_out_valid;
    t_kind                 r_out_kind, n_out_kind;
    logic [CLIENT_W-1:0]   r_out_client, n_out_client;
    logic [POS_W-1:0]      r_out_pos, n_out_pos;
    logic                  r_out_last, n_out_last;
    logic [POS_W-1:0]      r_out_count, n_out_count;

    logic [CW-1:0]         idx_p1, idx_p2, idx_m1, idx_m2, cnt_m1, cnt_p1;
    logic [XW-1:0]         pos_x, cnt_x, cnt_m1_x;
    logic [PERIOD_W-1:0]   tick_p1, period_eff;
    logic                  slot_free;

    // Index arithmetic for the walk
    assign idx_p1   = r_idx + CW'(1);
    assign idx_p2   = r_idx + CW'(2);
    assign idx_m1   = r_idx - CW'(1);
    assign idx_m2   = r_idx - CW'(2);
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_p1   = r_count + CW'(1);
    assign pos_x    = XW'(r_idx) + XW'(1);
    assign cnt_x    = XW'(r_count);
    assign cnt_m1_x = XW'(cnt_m1);

    // Timer helpers; a zero period behaves as one
    assign tick_p1    = r_tick + PERIOD_W'(1);
    assign period_eff = (i_period == '0) ? PERIOD_W'(1) : i_period;

    // Result register may be loaded when empty or being drained
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_dirty      = r_dirty;
        n_run        = r_run;
        n_tick       = r_tick;
        n_poll       = r_poll;
        n_cid        = r_cid;
        n_prio       = r_prio;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_client = r_out_client;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        n_out_count  = r_out_count;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx[AW-1:0];
        o_wr_data    = i_rd_data;
        o_rd_en      = 1'b0;
        o_rd_addr    = idx_p1[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cid  = i_client_id;
                    n_prio = i_priority_req;
                    case (i_mode)
                        MODE_ENQ: begin
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_state = S_REJ;
                            end else begin
                                n_dirty = 1'b1;
                                if (r_count == '0) begin
                                    n_run   = 1'b1;
                                    n_tick  = '0;
                                    n_idx   = '0;
                                    n_state = S_INS_FIN;
                                end else begin
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = cnt_m1[AW-1:0];
                                    n_idx     = r_count;
                                    n_state   = S_INS;
                                end
                            end
                        end
                        MODE_DEQ: begin
                            n_dirty   = 1'b1;
                            n_poll    = 1'b0;
                            n_idx     = '0;
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_state   = S_SRCH;
                        end
                        MODE_FREE: begin
                            if (r_count != '0) begin
                                n_dirty   = 1'b1;
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = S_FREE;
                            end
                        end
                        MODE_POLL: begin
                            n_poll    = 1'b1;
                            n_idx     = '0;
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_state   = S_SRCH;
                        end
                        MODE_TICK: begin
                            if (r_run) begin
                                if (tick_p1 >= period_eff) begin
                                    n_tick = '0;
                                    if (r_dirty) begin
                                        n_dirty = 1'b0;
                                        if (r_count != '0) begin
                                            o_rd_en   = 1'b1;
                                            o_rd_addr = '0;
                                            n_idx     = '0;
                                            n_state   = S_BCAST;
                                        end
                                    end
                                    if (r_count == '0) begin
                                        n_run = 1'b0;
                                    end
                                end else begin
                                    n_tick = tick_p1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Move larger priorities up one slot until the hole is in place
            S_INS: begin
                if (i_rd_data.prio > r_prio) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx[AW-1:0];
                    o_wr_data = i_rd_data;
                    n_idx     = idx_m1;
                    if (idx_m1 == '0) begin
                        n_state = S_INS_FIN;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = idx_m2[AW-1:0];
                    end
                end else begin
                    n_state = S_INS_FIN;
                end
            end

            S_INS_FIN: begin
                o_wr_en          = 1'b1;
                o_wr_addr        = r_idx[AW-1:0];
                o_wr_data.prio   = r_prio;
                o_wr_data.client = r_cid;
                n_count          = cnt_p1;
                n_state          = S_IDLE;
            end

            // Read data holds entry r_idx; the next entry is fetched ahead
            S_SRCH: begin
                if (r_idx >= r_count) begin
                    if (!r_poll) begin
                        n_state = S_IDLE;
                    end else if (slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_POLL;
                        n_out_client = r_cid;
                        n_out_pos    = '0;
                        n_out_last   = 1'b1;
                        n_out_count  = cnt_x[POS_W-1:0];
                        n_state      = S_IDLE;
                    end
                end else if (i_rd_data.client == r_cid) begin
                    if (!r_poll) begin
                        o_rd_en = 1'b1;
                        n_state = S_SHIFT;
                    end else if (slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_POLL;
                        n_out_client = r_cid;
                        n_out_pos    = pos_x[POS_W-1:0];
                        n_out_last   = 1'b1;
                        n_out_count  = cnt_x[POS_W-1:0];
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_rd_en = 1'b1;
                    n_idx   = idx_p1;
                end
            end

            // Close the hole at r_idx; read data holds entry r_idx + 1
            S_SHIFT: begin
                if (idx_p1 < r_count) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx[AW-1:0];
                    o_wr_data = i_rd_data;
                    o_rd_en   = 1'b1;
                    o_rd_addr = idx_p2[AW-1:0];
                    n_idx     = idx_p1;
                end else begin
                    n_count = cnt_m1;
                    n_state = S_IDLE;
                end
            end

            // Admit the front entry, then remove it
            S_FREE: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_ADMIT;
                    n_out_client = i_rd_data.client;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_out_count  = cnt_m1_x[POS_W-1:0];
                    o_rd_en      = 1'b1;
                    o_rd_addr    = AW'(1);
                    n_idx        = '0;
                    n_state      = S_SHIFT;
                end
            end

            S_REJ: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_REJECT;
                    n_out_client = r_cid;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_out_count  = cnt_x[POS_W-1:0];
                    n_state      = S_IDLE;
                end
            end

            // One position update per entry, front first
            S_BCAST: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_POS;
                    n_out_client = i_rd_data.client;
                    n_out_pos    = pos_x[POS_W-1:0];
                    n_out_last   = (idx_p1 == r_count);
                    n_out_count  = cnt_x[POS_W-1:0];
                    if (idx_p1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        o_rd_en = 1'b1;
                        n_idx   = idx_p1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_dirty     <= 1'b0;
            r_run       <= 1'b0;
            r_tick      <= '0;
            r_poll      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_dirty      <= n_dirty;
            r_run        <= n_run;
            r_tick       <= n_tick;
            r_poll       <= n_poll;
            r_cid        <= n_cid;
            r_prio       <= n_prio;
            r_out_valid  <= n_out_valid;
            r_out_kind   <= n_out_kind;
            r_out_client <= n_out_client;
            r_out_pos    <= n_out_pos;
            r_out_last   <= n_out_last;
            r_out_count  <= n_out_count;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_client_out  = r_out_client;
    assign o_position    = r_out_pos;
    assign o_last        = r_out_last;
    assign o_queue_count = r_out_count;
    assign o_count       = r_count;

endmodule
